// File: rtl/cmwc_pkg.sv
// ----------------------------------------------------------------------------
// CMWC4096 package
// Shared widths, constants and the request operation codes.
// ----------------------------------------------------------------------------
package cmwc_pkg;

   localparam int WORD_W    = 32;
   localparam int CARRY_W   = 19;
   localparam int MULT_W    = 15;
   localparam int PROD_W    = WORD_W + MULT_W;
   localparam int DIV_CNT_W = $clog2(WORD_W);

   localparam logic [WORD_W-1:0]  GOLDEN_WORD  = 32'h9e37_79b9;
   localparam logic [WORD_W-1:0]  CMWC_BASE_M1 = 32'hffff_fffe;
   localparam logic [MULT_W-1:0]  CMWC_MULT    = 15'd18782;
   localparam logic [CARRY_W-1:0] CARRY_RESET  = 19'd362436;

   typedef enum logic [1:0] {
      OP_RAW     = 2'd0,
      OP_BELOW   = 2'd1,
      OP_BETWEEN = 2'd2,
      OP_RESEED  = 2'd3
   } op_type;

endpackage

// File: rtl/cmwc_ram.sv
// ----------------------------------------------------------------------------
// CMWC generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module cmwc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/cmwc4096_random_generator.sv
// ----------------------------------------------------------------------------
// CMWC4096 random generator
// Complementary multiply-with-carry generator, lag table in RAM, with
// iterative range reduction.
// ----------------------------------------------------------------------------
// Usage: after reset the block fills the lag table from seed 0 and holds
// req_ready low meanwhile; csr writes are taken at any time but only matter
// at the next reseed transaction. A raw transaction goes through table read,
// multiply, carry fold with table write, and result. Below and between
// transactions add the restoring modulo unit, one quotient bit per cycle;
// between transactions also end with the final offset add. Requests that
// end in an error or an empty range do not touch the table. A reseed
// refills the whole table through the one table write port. One transaction
// is in work at a time; a finished response waits in the output register
// while the next request is accepted.
module cmwc4096_random_generator #(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [cmwc_pkg::WORD_W-1:0]  csr_write_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_operation,
   input  logic [cmwc_pkg::WORD_W-1:0]  req_lower_bound,
   input  logic [cmwc_pkg::WORD_W-1:0]  req_upper_bound,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [cmwc_pkg::WORD_W-1:0]  rsp_random_value,
   output logic                         rsp_error_flag
);
   import cmwc_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_FILL,
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_ADD,
      ST_DIV,
      ST_FIN,
      ST_DONE
   } state_type;

   state_type            state_ff;
   logic                 fill_rsp_ff;
   logic [IDX_W-1:0]     fill_cnt_ff;
   logic [WORD_W-1:0]    fill_a_ff, fill_b_ff, fill_c_ff;
   logic [WORD_W-1:0]    seed_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [CARRY_W-1:0]   carry_ff;
   op_type               op_ff;
   logic [WORD_W-1:0]    lower_ff;
   logic [WORD_W-1:0]    mod_ff;
   logic [WORD_W-1:0]    rem_ff;
   logic [WORD_W-1:0]    word_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [WORD_W-1:0]    res_val_ff;
   logic                 res_err_ff;
   logic                 rsp_valid_ff;
   logic [WORD_W-1:0]    rsp_val_ff;
   logic                 rsp_err_ff;

   logic [WORD_W-1:0]    fill_val_in;
   logic [PROD_W-1:0]    prod_in;
   logic [MULT_W-1:0]    cy_lo;
   logic [WORD_W:0]      sum_in;
   logic [WORD_W-1:0]    low_in;
   logic [CARRY_W-1:0]   carry_in;
   logic [WORD_W-1:0]    new_word_in;
   logic [WORD_W:0]      shift_in;
   logic [WORD_W:0]      diff_in;
   logic [WORD_W-1:0]    rem_in;

   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   logic [WORD_W-1:0]    ram_wr_data;
   logic [WORD_W-1:0]    ram_rd_data;

   op_type               req_op;
   logic                 req_fire;

   assign req_op   = op_type'(req_operation);
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire = req_valid && req_ready;

   // Lag table fill: first entry is the seed, next two step by the golden
   // word, the rest mix the entries three and two back with the index.
   always_comb begin
      if (fill_cnt_ff == '0) begin
         fill_val_in = seed_ff;
      end else if (fill_cnt_ff < IDX_W'(3)) begin
         fill_val_in = fill_c_ff + GOLDEN_WORD;
      end else begin
         fill_val_in = fill_a_ff ^ fill_b_ff ^ GOLDEN_WORD ^ WORD_W'(fill_cnt_ff);
      end
   end

   // Multiply-with-carry step and the base 2^32 - 1 fold.
   always_comb begin
      prod_in     = PROD_W'(CMWC_MULT) * PROD_W'(ram_rd_data) + PROD_W'(carry_ff);
      cy_lo       = prod_ff[PROD_W-1:WORD_W];
      sum_in      = {1'b0, prod_ff[WORD_W-1:0]} + (WORD_W+1)'(cy_lo);
      low_in      = sum_in[WORD_W-1:0] + WORD_W'(sum_in[WORD_W]);
      carry_in    = CARRY_W'(cy_lo) + CARRY_W'(sum_in[WORD_W]);
      new_word_in = CMWC_BASE_M1 - low_in;
   end

   // One restoring modulo step.
   always_comb begin
      shift_in = {rem_ff, word_ff[WORD_W-1]};
      diff_in  = shift_in - {1'b0, mod_ff};
      if (diff_in[WORD_W]) begin
         rem_in = shift_in[WORD_W-1:0];
      end else begin
         rem_in = diff_in[WORD_W-1:0];
      end
   end

   always_comb begin
      ram_wr_en   = (state_ff == ST_FILL) || (state_ff == ST_ADD);
      ram_wr_addr = (state_ff == ST_FILL) ? fill_cnt_ff : idx_ff;
      ram_wr_data = (state_ff == ST_FILL) ? fill_val_in : new_word_in;
   end

   cmwc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_DEPTH)
   ) u_lag_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         fill_rsp_ff  <= 1'b0;
         fill_cnt_ff  <= '0;
         seed_ff      <= '0;
         idx_ff       <= IDX_LAST;
         carry_ff     <= CARRY_RESET;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         if (csr_write_enable) begin
            seed_ff <= csr_write_data;
         end
         // the done state reloads the output register on its own
         if (rsp_valid_ff && rsp_ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_FILL: begin
               fill_a_ff   <= fill_b_ff;
               fill_b_ff   <= fill_c_ff;
               fill_c_ff   <= fill_val_in;
               fill_cnt_ff <= fill_cnt_ff + 1'b1;
               if (fill_cnt_ff == IDX_LAST) begin
                  res_val_ff <= '0;
                  res_err_ff <= 1'b0;
                  state_ff   <= fill_rsp_ff ? ST_DONE : ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_fire) begin
                  op_ff    <= req_op;
                  lower_ff <= req_lower_bound;
                  case (req_op)
                     OP_RAW: begin
                        res_err_ff <= 1'b0;
                        idx_ff     <= idx_ff + 1'b1;
                        state_ff   <= ST_READ;
                     end
                     OP_BELOW: begin
                        mod_ff <= req_upper_bound;
                        if (req_upper_bound == '0) begin
                           res_val_ff <= '0;
                           res_err_ff <= 1'b1;
                           state_ff   <= ST_DONE;
                        end else begin
                           res_err_ff <= 1'b0;
                           idx_ff     <= idx_ff + 1'b1;
                           state_ff   <= ST_READ;
                        end
                     end
                     OP_BETWEEN: begin
                        mod_ff <= req_upper_bound - req_lower_bound;
                        if (req_upper_bound < req_lower_bound) begin
                           res_val_ff <= '0;
                           res_err_ff <= 1'b1;
                           state_ff   <= ST_DONE;
                        end else if (req_upper_bound == req_lower_bound) begin
                           res_val_ff <= req_lower_bound;
                           res_err_ff <= 1'b0;
                           state_ff   <= ST_DONE;
                        end else begin
                           res_err_ff <= 1'b0;
                           idx_ff     <= idx_ff + 1'b1;
                           state_ff   <= ST_READ;
                        end
                     end
                     default: begin
                        // reseed: carry and index are kept
                        fill_cnt_ff <= '0;
                        fill_rsp_ff <= 1'b1;
                        state_ff    <= ST_FILL;
                     end
                  endcase
               end
            end
            ST_READ: begin
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               carry_ff <= carry_in;
               if (op_ff == OP_RAW) begin
                  res_val_ff <= new_word_in;
                  state_ff   <= ST_DONE;
               end else begin
                  word_ff    <= new_word_in;
                  rem_ff     <= '0;
                  div_cnt_ff <= '0;
                  state_ff   <= ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff     <= rem_in;
               word_ff    <= word_ff << 1;
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == DIV_CNT_W'(WORD_W - 1)) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               res_val_ff <= (op_ff == OP_BETWEEN) ? rem_ff + lower_ff : rem_ff;
               state_ff   <= ST_DONE;
            end
            ST_DONE: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_val_ff   <= res_val_ff;
                  rsp_err_ff   <= res_err_ff;
                  fill_rsp_ff  <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_val_ff;
   assign rsp_error_flag   = rsp_err_ff;

   a_div_nonzero_mod: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> mod_ff != '0)
      else $error("modulo unit running with zero modulus");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done state");

   a_idx_moves_on_accept: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(idx_ff) |-> $past(req_fire))
      else $error("table index moved without an accepted request");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE || state_ff == ST_DONE |-> !ram_wr_en)
      else $error("lag table written while no work is in progress");

endmodule

// File: tb/sv/tb_cmwc4096_random_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CMWC4096 random generator testbench
// Drives raw, below, between and reseed transactions through the request
// channel under random gaps and response stalls, and checks every response
// against an in-bench model of the lag table, carry and index, or against a
// value typed into the directed table. A directed table covers the bound
// extremes and the error and empty-range cases; random phases follow, each
// under a fresh seed.
module tb_cmwc4096_random_generator;
   import cmwc_pkg::*;

   localparam int DEPTH         = 4096;
   localparam int IDX_W         = $clog2(DEPTH);
   localparam int N_DIRECTED    = 25;
   localparam int N_PHASES      = 8;
   localparam int PHASE_ITEMS   = 250;
   localparam int CYCLE_LIMIT   = 20_000_000;
   localparam logic [WORD_W-1:0] ALL_ONES = 32'hffff_ffff;

   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic              err;
   } result_type;

   typedef struct packed {
      bit                write_seed;
      logic [WORD_W-1:0] seed;
      op_type            op;
      logic [WORD_W-1:0] lo;
      logic [WORD_W-1:0] hi;
      bit                fixed;
      logic [WORD_W-1:0] fixed_value;
      logic              fixed_err;
   } directed_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_enable = 1'b0;
   logic [WORD_W-1:0] csr_write_data = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_operation = OP_RAW;
   logic [WORD_W-1:0] req_lower_bound = '0;
   logic [WORD_W-1:0] req_upper_bound = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [WORD_W-1:0] rsp_random_value;
   logic              rsp_error_flag;

   cmwc4096_random_generator #(.TABLE_DEPTH(DEPTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_lower_bound  (req_lower_bound),
      .req_upper_bound  (req_upper_bound),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_random_value (rsp_random_value),
      .rsp_error_flag   (rsp_error_flag)
   );

   always #1 clock = ~clock;

   // Generator model state
   logic [WORD_W-1:0]  lag_copy [DEPTH];
   logic [CARRY_W-1:0] carry_copy;
   logic [IDX_W-1:0]   index_copy;
   logic [WORD_W-1:0]  seed_copy;

   result_type pending_results [$];
   directed_row_type directed_rows [N_DIRECTED];

   bit quiet_mode = 1'b0;
   int fail_count = 0;
   int cycle_count = 0;
   int checked_count = 0;
   int error_rsp_count = 0;
   int seed_settings = 0;
   int op_count [4] = '{0, 0, 0, 0};
   int stall_left = 0;

   function automatic void refill_lag(input logic [WORD_W-1:0] s);
      lag_copy[0] = s;
      lag_copy[1] = s + GOLDEN_WORD;
      lag_copy[2] = s + GOLDEN_WORD + GOLDEN_WORD;
      for (int k = 3; k < DEPTH; k++)
         lag_copy[k] = lag_copy[k-3] ^ lag_copy[k-2] ^ GOLDEN_WORD ^ 32'(k);
   endfunction

   function automatic logic [WORD_W-1:0] draw_word();
      logic [63:0]       prod;
      logic [WORD_W-1:0] low;
      logic [WORD_W-1:0] cy;
      index_copy = index_copy + 1'b1;
      prod = 64'(CMWC_MULT) * 64'(lag_copy[index_copy]) + 64'(carry_copy);
      cy   = prod[63:32];
      low  = prod[31:0] + cy;
      if (low < cy) begin
         low = low + 1;
         cy  = cy + 1;
      end
      carry_copy = cy[CARRY_W-1:0];
      lag_copy[index_copy] = CMWC_BASE_M1 - low;
      return lag_copy[index_copy];
   endfunction

   function automatic result_type predict_response(input op_type op,
                                                   input logic [WORD_W-1:0] lo,
                                                   input logic [WORD_W-1:0] hi);
      result_type r;
      r = '0;
      case (op)
         OP_RAW: begin
            r.value = draw_word();
         end
         OP_BELOW: begin
            if (hi == '0) r.err = 1'b1;
            else r.value = draw_word() % hi;
         end
         OP_BETWEEN: begin
            if (hi < lo) r.err = 1'b1;
            else if (hi == lo) r.value = lo;
            else r.value = lo + draw_word() % (hi - lo);
         end
         default: begin
            refill_lag(seed_copy);
         end
      endcase
      return r;
   endfunction

   // Idle length: mostly none, some short, a few long
   function automatic int idle_len();
      int r;
      if (quiet_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [WORD_W-1:0] pick_bound();
      int r;
      int k;
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 31);
      if (r < 30) return $urandom_range(1, 16);
      if (r < 50) return 32'd1 << k;
      if (r < 65) return ALL_ONES - $urandom_range(0, 15);
      if (r < 80) return (32'd1 << k) + ($urandom_range(0, 1) ? 32'd1 : ALL_ONES);
      return $urandom;
   endfunction

   task automatic send_request(input op_type op, input logic [WORD_W-1:0] lo,
                               input logic [WORD_W-1:0] hi, input bit fixed,
                               input logic [WORD_W-1:0] fixed_value,
                               input logic fixed_err);
      int         gap;
      result_type want;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_lower_bound <= lo;
      req_upper_bound <= hi;
      do @(posedge clock); while (!req_ready);
      // advance the model even where the response is typed in
      want = predict_response(op, lo, hi);
      if (fixed) begin
         want.value = fixed_value;
         want.err   = fixed_err;
      end
      pending_results.push_back(want);
      op_count[op]++;
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_seed(input logic [WORD_W-1:0] v);
      drain_responses();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      seed_copy = v;
      seed_settings++;
   endtask

   task automatic random_request();
      op_type            op;
      logic [WORD_W-1:0] lo;
      logic [WORD_W-1:0] hi;
      logic [WORD_W-1:0] span;
      int                r;
      int                sub;
      r   = $urandom_range(0, 99);
      sub = $urandom_range(0, 99);
      lo  = $urandom;
      hi  = $urandom;
      if (r < 1) begin
         op = OP_RESEED;
      end else if (r < 27) begin
         op = OP_RAW;
      end else if (r < 60) begin
         op = OP_BELOW;
         hi = (sub < 4) ? '0 : pick_bound();
      end else begin
         op = OP_BETWEEN;
         if (sub < 5) begin
            // upper below lower
            if (lo == '0) lo = 32'd1;
            hi = $urandom_range(0, lo - 1);
         end else if (sub < 10) begin
            hi = lo;
         end else begin
            span = pick_bound();
            if (lo > ALL_ONES - span) lo = ALL_ONES - span;
            hi = lo + span;
         end
      end
      send_request(op, lo, hi, 1'b0, '0, 1'b0);
   endtask

   // Response side: check and stall
   always @(posedge clock) begin : rsp_side
      result_type want;
      int         g;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected transaction: random_value %h error_flag %b",
                   rsp_random_value, rsp_error_flag);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_random_value !== want.value) begin
               $error("random_value mismatch: expected %h, got %h",
                      want.value, rsp_random_value);
               fail_count++;
            end
            if (rsp_error_flag !== want.err) begin
               $error("error_flag mismatch: expected %b, got %b",
                      want.err, rsp_error_flag);
               fail_count++;
            end
            if (rsp_error_flag === 1'b1) error_rsp_count++;
            checked_count++;
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         g = idle_len();
         if (g == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready  <= 1'b0;
            stall_left = g - 1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_results.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      logic [WORD_W-1:0] phase_seeds [N_PHASES];

      directed_rows = '{
         '{1'b0, '0, OP_RAW,     '0,            '0,            1'b0, '0, 1'b0},
         '{1'b0, '0, OP_RAW,     ALL_ONES,      ALL_ONES,      1'b0, '0, 1'b0},
         '{1'b0, '0, OP_BELOW,   '0,            '0,            1'b1, '0, 1'b1},
         '{1'b0, '0, OP_BELOW,   ALL_ONES,      32'd1,         1'b1, '0, 1'b0},
         '{1'b0, '0, OP_BELOW,   '0,            ALL_ONES,      1'b0, '0, 1'b0},
         '{1'b0, '0, OP_BELOW,   '0,            32'h8000_0000, 1'b0, '0, 1'b0},
         '{1'b0, '0, OP_BELOW,   '0,            32'd7,         1'b0, '0, 1'b0},
         '{1'b0, '0, OP_BETWEEN, 32'd5,         32'd5,         1'b1, 32'd5, 1'b0},
         '{1'b0, '0, OP_BETWEEN, '0,            '0,            1'b1, '0, 1'b0},
         '{1'b0, '0, OP_BETWEEN, ALL_ONES,      ALL_ONES,      1'b1, ALL_ONES, 1'b0},
         '{1'b0, '0, OP_BETWEEN, 32'd10,        32'd9,         1'b1, '0, 1'b1},
         '{1'b0, '0, OP_BETWEEN, ALL_ONES,      '0,            1'b1, '0, 1'b1},
         '{1'b0, '0, OP_BETWEEN, '0,            ALL_ONES,      1'b0, '0, 1'b0},
         '{1'b0, '0, OP_BETWEEN, 32'hffff_fffe, ALL_ONES,      1'b1, 32'hffff_fffe, 1'b0},
         '{1'b0, '0, OP_BETWEEN, 32'd100,       32'd200,       1'b0, '0, 1'b0},
         // reseed refills the table but keeps carry and index
         '{1'b0, '0, OP_RESEED,  ALL_ONES,      ALL_ONES,      1'b1, '0, 1'b0},
         '{1'b0, '0, OP_RAW,     '0,            '0,            1'b0, '0, 1'b0},
         // a seed write alone leaves the table as it is
         '{1'b1, ALL_ONES, OP_RAW, '0,          '0,            1'b0, '0, 1'b0},
         '{1'b0, '0, OP_RAW,     '0,            '0,            1'b0, '0, 1'b0},
         '{1'b0, '0, OP_RESEED,  '0,            '0,            1'b1, '0, 1'b0},
         '{1'b0, '0, OP_RAW,     '0,            '0,            1'b0, '0, 1'b0},
         '{1'b0, '0, OP_BELOW,   '0,            32'h5555_5555, 1'b0, '0, 1'b0},
         '{1'b0, '0, OP_BETWEEN, 32'haaaa_aaaa, ALL_ONES,      1'b0, '0, 1'b0},
         '{1'b1, 32'h8000_0000, OP_RESEED, 32'd1, '0,          1'b1, '0, 1'b0},
         '{1'b0, '0, OP_BETWEEN, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 32'h7fff_ffff, 1'b0}
      };
      phase_seeds = '{ALL_ONES, '0, $urandom, $urandom, 32'h8000_0000, 32'd1,
                      $urandom, 32'h7fff_ffff};

      seed_copy  = '0;
      carry_copy = CARRY_RESET;
      index_copy = IDX_W'(DEPTH - 1);
      refill_lag(seed_copy);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         if (directed_rows[i].write_seed) write_seed(directed_rows[i].seed);
         send_request(directed_rows[i].op, directed_rows[i].lo, directed_rows[i].hi,
                      directed_rows[i].fixed, directed_rows[i].fixed_value,
                      directed_rows[i].fixed_err);
      end

      for (int p = 0; p < N_PHASES; p++) begin
         write_seed(phase_seeds[p]);
         // hold both sides busy for one whole phase
         quiet_mode = (p == 5);
         send_request(OP_RESEED, $urandom, $urandom, 1'b0, '0, 1'b0);
         for (int n = 0; n < PHASE_ITEMS; n++) random_request();
      end
      quiet_mode = 1'b0;

      drain_responses();
      repeat (50) @(posedge clock);

      $display("checked %0d responses: raw %0d, below %0d, between %0d, reseed %0d",
               checked_count, op_count[OP_RAW], op_count[OP_BELOW],
               op_count[OP_BETWEEN], op_count[OP_RESEED]);
      $display("%0d error responses, %0d seed settings, %0d cycles",
               error_rsp_count, seed_settings, cycle_count);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/cmwc_pkg.sv
rtl/cmwc_ram.sv
rtl/cmwc4096_random_generator.sv
tb/sv/tb_cmwc4096_random_generator.sv
